/* src/rncs_pkg.sv */
`timescale 1ns / 1ps

package rncs_pkg;

   // sizes of the tour problem
   localparam int MAX_CITIES  = 32;
   localparam int NUM_ANTS    = 8;
   localparam int WEIGHT_BITS = 16;
   localparam int FRAC_W      = 16;

   // derived widths
   localparam int CITY_W  = $clog2(MAX_CITIES);
   localparam int ANT_W   = $clog2(NUM_ANTS);
   localparam int COUNT_W = 6;
   localparam int ADDR_W  = 2 * CITY_W;
   localparam int SUM_W   = WEIGHT_BITS + CITY_W;
   localparam int PROD_W  = SUM_W + FRAC_W;

   localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = COUNT_W'(MAX_CITIES);
   localparam logic [COUNT_W-1:0] CITY_COUNT_MIN   = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] CITY_COUNT_MAX   = COUNT_W'(MAX_CITIES);

   // item opcodes
   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_START  = 2'd1,
      FUNC_CHOOSE = 2'd2
   } func_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the accepted item
      logic mem_wr;      // write the weight table
      logic run;         // sweep the weight row
      logic scan;        // sweep compares against the threshold
      logic pass_start;  // compute threshold, rewind the sweep
      logic emit;        // update ant state and load the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_ok;
      logic pass_done;
      logic none_left;
      logic total_zero;
      logic out_free;
   } ctrl_status_type;

endpackage

/* src/rncs_ctrl.sv */
`timescale 1ns / 1ps

module rncs_ctrl
   import rncs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [1:0]      req_func,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MULT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_func)
                  FUNC_WRITE:  cmd.mem_wr = 1'b1;
                  FUNC_START: begin
                     if (status.start_ok) state_in = ST_FINISH;
                  end
                  FUNC_CHOOSE: state_in = ST_SUM;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SUM: begin
            cmd.run = 1'b1;
            if (status.pass_done) begin
               if (status.none_left || status.total_zero) state_in = ST_FINISH;
               else state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.pass_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.run  = 1'b1;
            cmd.scan = 1'b1;
            if (status.pass_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/rncs_dp.sv */
`timescale 1ns / 1ps

module rncs_dp
   import rncs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_func,
   input  logic [ANT_W-1:0]       req_ant,
   input  logic [CITY_W-1:0]      req_from_city,
   input  logic [CITY_W-1:0]      req_to_city,
   input  logic [WEIGHT_BITS-1:0] req_weight_value,
   input  logic [FRAC_W-1:0]      req_random_fraction,
   input  logic                   csr_wr_en,
   input  logic [COUNT_W-1:0]     csr_wr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [CITY_W-1:0]      rsp_chosen_city,
   output logic                   rsp_tour_complete,
   output logic                   rsp_no_city_left,
   input  ctrl_cmd_type           cmd,
   output ctrl_status_type        status
);

   // configuration
   logic [COUNT_W-1:0]    city_count_ff;
   logic [COUNT_W-1:0]    n_eff;
   logic [MAX_CITIES-1:0] city_mask;

   // per-ant state
   logic [MAX_CITIES-1:0] visited_ff [NUM_ANTS];
   logic [CITY_W-1:0]     current_ff [NUM_ANTS];

   // weight table
   logic [WEIGHT_BITS-1:0] weight_mem [MAX_CITIES * MAX_CITIES];
   logic [WEIGHT_BITS-1:0] rdata_ff;

   // captured item
   logic [1:0]            func_ff;
   logic [ANT_W-1:0]      ant_ff;
   logic [CITY_W-1:0]     to_ff;
   logic [FRAC_W-1:0]     frac_ff;
   logic [MAX_CITIES-1:0] row_ff;
   logic [CITY_W-1:0]     cur_ff;

   // sweep
   logic [COUNT_W-1:0] rd_idx_ff;
   logic               rd_vld_ff;
   logic [CITY_W-1:0]  rd_tag_ff;
   logic               issue;
   logic [SUM_W-1:0]   total_ff;
   logic [SUM_W-1:0]   thr_ff;
   logic [SUM_W-1:0]   run_ff;
   logic [SUM_W-1:0]   run_in;
   logic               found_ff;
   logic [CITY_W-1:0]  pick_ff;
   logic [PROD_W-1:0]  product;

   // selection and result
   logic [MAX_CITIES-1:0] avail;
   logic [CITY_W-1:0]     lowest;
   logic [CITY_W-1:0]     pick;
   logic [MAX_CITIES-1:0] new_row;
   logic                  none_left;
   logic                  is_start;
   logic                  rsp_valid_ff;
   logic [CITY_W-1:0]     chosen_ff;
   logic                  complete_ff;
   logic                  no_left_ff;

   // city count register
   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CITY_COUNT_RESET;
      end else if (csr_wr_en) begin
         city_count_ff <= csr_wr_data;
      end
   end

   // clamp the count and build the in-use mask
   always_comb begin
      if (city_count_ff < CITY_COUNT_MIN) n_eff = CITY_COUNT_MIN;
      else if (city_count_ff > CITY_COUNT_MAX) n_eff = CITY_COUNT_MAX;
      else n_eff = city_count_ff;
      for (int c = 0; c < MAX_CITIES; c++) begin
         city_mask[c] = (COUNT_W'(c) < n_eff);
      end
   end

   // lowest unvisited city in use
   always_comb begin
      avail  = ~row_ff & city_mask;
      lowest = '0;
      for (int c = MAX_CITIES - 1; c >= 0; c--) begin
         if (avail[c]) lowest = CITY_W'(c);
      end
   end

   assign none_left = (avail == '0);
   assign is_start  = (func_ff == FUNC_START);

   // city placed and the ant's map afterwards
   always_comb begin
      if (is_start) begin
         pick    = to_ff;
         new_row = MAX_CITIES'(1) << to_ff;
      end else if (none_left) begin
         pick    = cur_ff;
         new_row = row_ff;
      end else begin
         pick    = found_ff ? pick_ff : lowest;
         new_row = row_ff | (MAX_CITIES'(1) << pick);
      end
   end

   // weight table write port
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         weight_mem[{req_from_city, req_to_city}] <= req_weight_value;
      end
   end

   // weight table read port, one entry of the row per cycle
   assign issue = cmd.run && (rd_idx_ff != n_eff);

   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= weight_mem[{cur_ff, rd_idx_ff[CITY_W-1:0]}];
      end
   end

   // sweep control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         rd_idx_ff <= '0;
      end else begin
         rd_vld_ff <= issue;
         if (cmd.load || cmd.pass_start) rd_idx_ff <= '0;
         else if (issue) rd_idx_ff <= rd_idx_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (issue) rd_tag_ff <= rd_idx_ff[CITY_W-1:0];
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         ant_ff  <= req_ant;
         to_ff   <= req_to_city;
         frac_ff <= req_random_fraction;
         row_ff  <= visited_ff[req_ant];
         cur_ff  <= current_ff[req_ant];
      end
   end

   // threshold = total * fraction / 65536
   assign product = PROD_W'(total_ff) * PROD_W'(frac_ff);
   assign run_in  = run_ff + SUM_W'(rdata_ff);

   // accumulate the total, then find the first city past the threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (rd_vld_ff && cmd.scan && !row_ff[rd_tag_ff] && !found_ff
                   && (run_in > thr_ff)) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         total_ff <= '0;
         run_ff   <= '0;
      end else if (cmd.pass_start) begin
         thr_ff <= product[PROD_W-1:FRAC_W];
      end else if (rd_vld_ff && !row_ff[rd_tag_ff]) begin
         if (cmd.scan) begin
            run_ff <= run_in;
            if (!found_ff && (run_in > thr_ff)) pick_ff <= rd_tag_ff;
         end else begin
            total_ff <= total_ff + SUM_W'(rdata_ff);
         end
      end
   end

   // per-ant state update on result
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_ANTS; a++) begin
            visited_ff[a] <= '0;
            current_ff[a] <= '0;
         end
      end else if (cmd.emit) begin
         visited_ff[ant_ff] <= new_row;
         current_ff[ant_ff] <= pick;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         chosen_ff   <= pick;
         complete_ff <= ((new_row & city_mask) == city_mask);
         no_left_ff  <= !is_start && none_left;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_city   = chosen_ff;
   assign rsp_tour_complete = complete_ff;
   assign rsp_no_city_left  = no_left_ff;

   // status to the controller
   assign status.start_ok   = (COUNT_W'(req_to_city) < n_eff);
   assign status.pass_done  = (rd_idx_ff == n_eff) && !rd_vld_ff;
   assign status.none_left  = none_left;
   assign status.total_zero = (total_ff == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

/* src/roulette_next_city_select.sv */
`timescale 1ns / 1ps
// Next-city selector for ant colony tour construction (roulette wheel).
// Input channel req_*: valid/ready, one item per transfer. func selects a
// weight table write, an ant start, or a choose of the ant's next city.
// Output channel rsp_*: valid/ready, one result per start or choose item;
// writes, unused opcodes and out-of-range start cities give none.
// csr_wr_en/csr_wr_data set the city count n (clamped to 2..32).
// Writes can follow each other every cycle. A start goes straight to
// loading its result into the output register once that is free.
// A choose sweeps the 1024-entry weight table's single read port twice
// over the ant's row of n cities in use, one entry per cycle; it sweeps
// only once when the unvisited weights sum to zero or no city is left.
// One item is in work at a time; the next is taken the cycle after its
// result is loaded, even while that result still waits in the output
// register. If the receiver stalls with a result pending, a finished item
// holds until the register frees, then input is taken again.
// Reset clears all ants' visited maps and current cities and sets n to 32;
// the weight table is not cleared and must be written before use.
module roulette_next_city_select
   import rncs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [ANT_W-1:0]       req_ant,
   input  logic [CITY_W-1:0]      req_from_city,
   input  logic [CITY_W-1:0]      req_to_city,
   input  logic [WEIGHT_BITS-1:0] req_weight_value,
   input  logic [FRAC_W-1:0]      req_random_fraction,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CITY_W-1:0]      rsp_chosen_city,
   output logic                   rsp_tour_complete,
   output logic                   rsp_no_city_left,
   input  logic                   csr_wr_en,
   input  logic [COUNT_W-1:0]     csr_wr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer
   rncs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table, ant state and selection arithmetic
   rncs_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_func            (req_func),
      .req_ant             (req_ant),
      .req_from_city       (req_from_city),
      .req_to_city         (req_to_city),
      .req_weight_value    (req_weight_value),
      .req_random_fraction (req_random_fraction),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_chosen_city     (rsp_chosen_city),
      .rsp_tour_complete   (rsp_tour_complete),
      .rsp_no_city_left    (rsp_no_city_left),
      .cmd                 (cmd),
      .status              (status)
   );

   // a result is only loaded into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded over a pending result");

   // a loaded result is presented the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("loaded result not presented");

   // no input is taken while a row sweep runs
   assert property (@(posedge clock) disable iff (reset)
      cmd.run |-> !req_ready)
      else $error("input ready during row sweep");

   // an exhausted ant always reports a complete tour
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_city_left) |-> rsp_tour_complete)
      else $error("no city left without tour complete");

endmodule
